// ===== rtl/sism_pkg.sv =====
package sism_pkg;

    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef logic [1:0] mode_t;
    typedef logic [2:0] oper_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] status_t;

    localparam mode_t MODE_LOAD_A = 2'd0;
    localparam mode_t MODE_LOAD_B = 2'd1;
    localparam mode_t MODE_START  = 2'd2;
    localparam mode_t MODE_CLEAR  = 2'd3;

    localparam oper_t OP_UNION  = 3'd0;
    localparam oper_t OP_INTER  = 3'd1;
    localparam oper_t OP_DIFF   = 3'd2;
    localparam oper_t OP_SUBSET = 3'd3;
    localparam oper_t OP_OVERLAP = 3'd4;
    localparam oper_t OP_COUNT  = 3'd5;
    localparam oper_t OP_EQUAL  = 3'd6;
    localparam oper_t OP_LEX    = 3'd7;

    localparam kind_t KIND_ACK    = 2'd0;
    localparam kind_t KIND_ELEM   = 2'd1;
    localparam kind_t KIND_EMPTY  = 2'd2;
    localparam kind_t KIND_SCALAR = 2'd3;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_FULL    = 2'd1;
    localparam status_t STAT_NOT_ASC = 2'd2;
    localparam status_t STAT_BAD_OP  = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
    } store_ctrl_t;

endpackage

// ===== rtl/sism_set_store.sv =====
module sism_set_store
    import sism_pkg::*;
#(
    parameter int SET_DEPTH   = 32,
    parameter int INDEX_WIDTH = 32,
    parameter int CW          = $clog2(SET_DEPTH + 1),
    parameter int AW          = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  store_ctrl_t            ctrl,
    input  logic [INDEX_WIDTH-1:0] wr_elem,
    input  logic [CW-1:0]          rd_ptr,
    output logic [CW-1:0]          count,
    output status_t                load_status,
    output logic [INDEX_WIDTH-1:0] rd_data
);

    logic [INDEX_WIDTH-1:0] mem [SET_DEPTH];
    logic [CW-1:0]          count_reg;
    logic [INDEX_WIDTH-1:0] last_reg;
    logic [INDEX_WIDTH-1:0] rd_data_reg;
    logic                   wr_ok;

    always_comb begin
        priority if (count_reg == CW'(SET_DEPTH)) begin
            load_status = STAT_FULL;
        end else if (count_reg != '0 && wr_elem <= last_reg) begin
            load_status = STAT_NOT_ASC;
        end else begin
            load_status = STAT_OK;
        end
    end

    assign wr_ok = ctrl.load && (load_status == STAT_OK);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctrl.clear) begin
            count_reg <= '0;
        end else if (wr_ok) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            mem[count_reg[AW-1:0]] <= wr_elem;
            last_reg               <= wr_elem;
        end
        rd_data_reg <= mem[rd_ptr[AW-1:0]];
    end

    assign count   = count_reg;
    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/sorted_index_set_merge.sv =====
// Channel   Direction  tdata                                   tuser
// s_        in         element [31:0], operation [34:32]       mode
// m_        out        value [31:0], status [33:32]            kind
//
// A load or clear request gives its acknowledge in the next cycle.
// A merge run steps once per cycle while the result side is not stalled, one entry
// of A, of B or of both; the single read port of each store sets this rate.
// Reset clears the counts and the control state; the stores need no clearing.
// Any stall on the result side holds the run; no new request is taken during a run.
module sorted_index_set_merge
    import sism_pkg::*;
#(
    parameter int SET_DEPTH   = 32,
    parameter int INDEX_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // element, operation
    input  logic [1:0]           s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // value, status
    output logic [1:0]           m_tuser,   // kind
    output logic                 m_tlast
);

    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int AW = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                   state_reg, state_next;
    oper_t                  op_reg;
    logic [CW-1:0]          i_reg, i_next, j_reg, j_next;
    logic [CW-1:0]          match_reg, match_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [INDEX_WIDTH-1:0] pend_value_reg, pend_value_next;

    logic                   m_valid_reg;
    logic [VALUE_W-1:0]     m_value_reg;
    status_t                m_status_reg;
    kind_t                  m_kind_reg;
    logic                   m_last_reg;

    logic                   out_free, in_acc;
    logic                   out_load;
    kind_t                  out_kind;
    logic [VALUE_W-1:0]     out_value;
    status_t                out_status;
    logic                   out_last;

    mode_t                  in_mode;
    oper_t                  in_op;
    logic [INDEX_WIDTH-1:0] in_elem;

    store_ctrl_t            ctrl_a, ctrl_b;
    logic [CW-1:0]          cnt_a, cnt_b;
    status_t                ld_stat_a, ld_stat_b;
    logic [INDEX_WIDTH-1:0] rd_a, rd_b;

    logic                   a_live, b_live, a_lt, a_eq, finish, emit;
    logic [INDEX_WIDTH-1:0] emit_value;

    assign in_mode  = s_tuser;
    assign in_elem  = s_tdata[INDEX_WIDTH-1:0];
    assign in_op    = s_tdata[34:32];
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    assign ctrl_a.load  = in_acc && (in_mode == MODE_LOAD_A);
    assign ctrl_a.clear = in_acc && (in_mode == MODE_CLEAR);
    assign ctrl_b.load  = in_acc && (in_mode == MODE_LOAD_B);
    assign ctrl_b.clear = in_acc && (in_mode == MODE_CLEAR);

    sism_set_store #(
        .SET_DEPTH   (SET_DEPTH),
        .INDEX_WIDTH (INDEX_WIDTH),
        .CW          (CW),
        .AW          (AW)
    ) u_store_a (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl_a),
        .wr_elem     (in_elem),
        .rd_ptr      (i_next),
        .count       (cnt_a),
        .load_status (ld_stat_a),
        .rd_data     (rd_a)
    );

    sism_set_store #(
        .SET_DEPTH   (SET_DEPTH),
        .INDEX_WIDTH (INDEX_WIDTH),
        .CW          (CW),
        .AW          (AW)
    ) u_store_b (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl_b),
        .wr_elem     (in_elem),
        .rd_ptr      (j_next),
        .count       (cnt_b),
        .load_status (ld_stat_b),
        .rd_data     (rd_b)
    );

    assign a_live = i_reg < cnt_a;
    assign b_live = j_reg < cnt_b;
    assign a_lt   = rd_a < rd_b;
    assign a_eq   = rd_a == rd_b;

    always_comb begin
        state_next      = state_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        match_next      = match_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        out_load        = 1'b0;
        out_kind        = KIND_ACK;
        out_value       = '0;
        out_status      = STAT_OK;
        out_last        = 1'b1;
        finish          = 1'b0;
        emit            = 1'b0;
        emit_value      = rd_a;

        if (state_reg == ST_IDLE) begin
            if (in_acc) begin
                unique case (in_mode)
                    MODE_LOAD_A: begin
                        out_load   = 1'b1;
                        out_status = ld_stat_a;
                        out_value  = VALUE_W'(cnt_a) + VALUE_W'(ld_stat_a == STAT_OK);
                    end
                    MODE_LOAD_B: begin
                        out_load   = 1'b1;
                        out_status = ld_stat_b;
                        out_value  = VALUE_W'(cnt_b) + VALUE_W'(ld_stat_b == STAT_OK);
                    end
                    MODE_CLEAR: begin
                        out_load = 1'b1;
                    end
                    MODE_START: begin
                        state_next      = ST_RUN;
                        i_next          = '0;
                        j_next          = '0;
                        match_next      = '0;
                        pend_valid_next = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end else if (out_free) begin
            if (op_reg == OP_UNION || op_reg == OP_INTER || op_reg == OP_DIFF) begin
                unique case (op_reg)
                    OP_UNION: finish = !a_live && !b_live;
                    OP_INTER: finish = !a_live || !b_live;
                    default:  finish = !a_live;
                endcase
                if (finish) begin
                    out_load        = 1'b1;
                    out_kind        = pend_valid_reg ? KIND_ELEM : KIND_EMPTY;
                    out_value       = pend_valid_reg ? VALUE_W'(pend_value_reg) : '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end else begin
                    priority if (a_live && b_live && a_eq) begin
                        emit       = (op_reg != OP_DIFF);
                        match_next = match_reg + CW'(1);
                        i_next     = i_reg + CW'(1);
                        j_next     = j_reg + CW'(1);
                    end else if (a_live && (!b_live || a_lt)) begin
                        emit   = (op_reg != OP_INTER);
                        i_next = i_reg + CW'(1);
                    end else begin
                        emit       = (op_reg == OP_UNION);
                        emit_value = rd_b;
                        j_next     = j_reg + CW'(1);
                    end
                    if (emit) begin
                        out_load        = pend_valid_reg;
                        out_kind        = KIND_ELEM;
                        out_value       = VALUE_W'(pend_value_reg);
                        out_last        = 1'b0;
                        pend_valid_next = 1'b1;
                        pend_value_next = emit_value;
                    end
                end
            end else begin
                out_kind = KIND_SCALAR;
                priority if (!(a_live && b_live)) begin
                    finish = 1'b1;
                    unique case (op_reg)
                        OP_SUBSET:  out_value = VALUE_W'(!b_live);
                        OP_OVERLAP: out_value = '0;
                        OP_COUNT:   out_value = VALUE_W'(match_reg);
                        OP_EQUAL:   out_value = VALUE_W'(!a_live && !b_live);
                        default:    out_value = a_live ? VALUE_W'(1) :
                                                (b_live ? VALUE_W'(2) : '0);
                    endcase
                end else if (a_eq) begin
                    match_next = match_reg + CW'(1);
                    i_next     = i_reg + CW'(1);
                    j_next     = j_reg + CW'(1);
                    if (op_reg == OP_OVERLAP) begin
                        finish    = 1'b1;
                        out_value = VALUE_W'(1);
                    end
                end else if (a_lt) begin
                    unique case (op_reg)
                        OP_EQUAL: finish = 1'b1;
                        OP_LEX: begin
                            finish    = 1'b1;
                            out_value = VALUE_W'(1);
                        end
                        default: i_next = i_reg + CW'(1);
                    endcase
                end else begin
                    unique case (op_reg)
                        OP_SUBSET, OP_EQUAL: finish = 1'b1;
                        OP_LEX: begin
                            finish    = 1'b1;
                            out_value = VALUE_W'(2);
                        end
                        default: j_next = j_reg + CW'(1);
                    endcase
                end
                if (finish) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            match_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            match_reg      <= match_next;
            pend_valid_reg <= pend_valid_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_value_reg <= pend_value_next;
        if (in_acc && in_mode == MODE_START) begin
            op_reg <= in_op;
        end
        if (out_load) begin
            m_kind_reg   <= out_kind;
            m_value_reg  <= out_value;
            m_status_reg <= out_status;
            m_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_status_reg, m_value_reg});
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/sism_checker.sv =====
module sism_checker
    import sism_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser,
    input logic                 m_tlast
);

    // A load or clear request is acknowledged in the very next cycle.
    a_ack_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != MODE_START)
        |=> m_tvalid && m_tlast && (m_tuser == KIND_ACK))
        else $error("load or clear request without acknowledge");

    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tlast && (m_tdata[31:0] == 32'd0))
        else $error("malformed empty set marker");

    a_scalar_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_SCALAR || m_tuser == KIND_ACK) |-> m_tlast)
        else $error("scalar or acknowledge without last mark");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind sorted_index_set_merge sism_checker u_sism_checker (.*);
